### rtl/core/pdmu_pkg.sv
// ----------------------------------------------------------------------------
// pdmu_pkg
// Layout codes, widths and helpers for the packed distance matrix unpacker.
// ----------------------------------------------------------------------------
`default_nettype none

package pdmu_pkg;

  localparam int MAX_NODES = 1024;
  localparam int IDX_W     = $clog2(MAX_NODES);
  localparam int CNT_W     = IDX_W + 1;
  localparam int NC_W      = 11;
  localparam int FMT_W     = 4;
  localparam int WGT_W     = 32;
  localparam int OUT_IDX_W = 10;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 11;
  localparam int STAT_W    = 2;
  localparam int NCMP_W    = (NC_W > CNT_W) ? NC_W : CNT_W;

  localparam logic [CFG_IDX_W-1:0] REG_FORMAT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_NODES  = 1'b1;

  localparam logic [FMT_W-1:0] FMT_FULL         = 4'd0;
  localparam logic [FMT_W-1:0] FMT_UPPER_ROW    = 4'd1;
  localparam logic [FMT_W-1:0] FMT_LOWER_ROW    = 4'd2;
  localparam logic [FMT_W-1:0] FMT_UPPER_DG_ROW = 4'd3;
  localparam logic [FMT_W-1:0] FMT_LOWER_DG_ROW = 4'd4;
  localparam logic [FMT_W-1:0] FMT_UPPER_COL    = 4'd5;
  localparam logic [FMT_W-1:0] FMT_LOWER_COL    = 4'd6;
  localparam logic [FMT_W-1:0] FMT_UPPER_DG_COL = 4'd7;
  localparam logic [FMT_W-1:0] FMT_LOWER_DG_COL = 4'd8;

  localparam logic [STAT_W-1:0] ST_PROGRESS = 2'd0;
  localparam logic [STAT_W-1:0] ST_COMPLETE = 2'd1;
  localparam logic [STAT_W-1:0] ST_SHORT    = 2'd2;
  localparam logic [STAT_W-1:0] ST_EXTRA    = 2'd3;

  typedef struct packed {
    logic [OUT_IDX_W-1:0]    row;
    logic [OUT_IDX_W-1:0]    col;
    logic signed [WGT_W-1:0] value;
    logic                    wvalid;
    logic                    mirror;
    logic [STAT_W-1:0]       status;
  } result_t;

  function automatic logic [FMT_W-1:0] eff_format(input logic [FMT_W-1:0] fmt);
    return (fmt > FMT_LOWER_DG_COL) ? FMT_FULL : fmt;
  endfunction

  function automatic logic [CNT_W-1:0] eff_nodes(input logic [NC_W-1:0] nc);
    logic [NCMP_W-1:0] v;
    v = NCMP_W'(nc);
    if (v == '0) begin
      v = NCMP_W'(1);
    end else if (v > NCMP_W'(MAX_NODES)) begin
      v = NCMP_W'(MAX_NODES);
    end
    return CNT_W'(v);
  endfunction

endpackage

`default_nettype wire

### rtl/core/packed_distance_matrix_unpacker.sv
// ----------------------------------------------------------------------------
// packed_distance_matrix_unpacker
// Maps a stream of packed edge weights onto matrix cells for nine layouts.
//
//   port group | direction | handshake          | carries
//   in_*       | input     | in_valid/in_ready   | one weight word, last flag
//   out_*      | output    | out_valid/out_ready | cell, weight, flags, status
//   cfg_*      | input     | cfg_wr_en           | layout and node count
//
// One word enters per cycle while in_ready is high; its result is registered
// in the output register. A second word is held in a skid register while the
// output stalls, so in_ready falls only when both are full. Reset is synchronous and
// restarts the section at cell (0,0) with the full-matrix layout and one node.
// ----------------------------------------------------------------------------
`default_nettype none

module packed_distance_matrix_unpacker
  import pdmu_pkg::*;
(
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          cfg_wr_en,
  input  wire  [CFG_IDX_W-1:0]         cfg_index,
  input  wire  [CFG_DAT_W-1:0]         cfg_wdata,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire  signed [WGT_W-1:0]      in_weight_in,
  input  wire                          in_last_value,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic [OUT_IDX_W-1:0]         out_write_row,
  output logic [OUT_IDX_W-1:0]         out_write_col,
  output logic signed [WGT_W-1:0]      out_write_value,
  output logic                         out_write_valid,
  output logic                         out_mirror_write,
  output logic [STAT_W-1:0]            out_status
);

  logic [FMT_W-1:0] fmt_r, fmt_nxt;
  logic [NC_W-1:0]  nc_r, nc_nxt;
  logic [IDX_W-1:0] cur_row_r, cur_row_nxt, cur_col_r, cur_col_nxt;
  logic             section_full_r, section_full_nxt;
  logic             extra_seen_r, extra_seen_nxt;

  logic             out_valid_r, out_valid_nxt, skid_valid_r, skid_valid_nxt;
  result_t          out_res_r, out_res_nxt, skid_res_r, skid_res_nxt;

  logic [FMT_W-1:0] fmt_eff, st_fmt;
  logic [CNT_W-1:0] n_eff, st_n;
  logic [CNT_W-1:0] r_ext, c_ext, r1, c1;
  logic             adv_done;
  logic [IDX_W-1:0] st_row, st_col;
  logic             st_full;
  logic             in_fire, out_take, full_now, extra_now;
  result_t          res;

  assign in_ready = !skid_valid_r;
  assign in_fire  = in_valid && in_ready;
  assign out_take = out_valid_r && out_ready;

  assign fmt_eff = eff_format(fmt_r);
  assign n_eff   = eff_nodes(nc_r);
  assign r_ext   = CNT_W'(cur_row_r);
  assign c_ext   = CNT_W'(cur_col_r);

  // step to the next cell in layout order
  always_comb begin
    r1       = r_ext;
    c1       = c_ext;
    adv_done = 1'b0;
    unique case (fmt_eff)
      FMT_UPPER_ROW: begin
        c1 = c_ext + 1'b1;
        if (c1 >= n_eff) begin
          r1 = r_ext + 1'b1;
          c1 = r_ext + CNT_W'(2);
          adv_done = (c1 >= n_eff);
        end
      end
      FMT_LOWER_ROW: begin
        c1 = c_ext + 1'b1;
        if (c1 >= r_ext) begin
          r1 = r_ext + 1'b1;
          c1 = '0;
          adv_done = (r1 >= n_eff);
        end
      end
      FMT_UPPER_DG_ROW: begin
        c1 = c_ext + 1'b1;
        if (c1 >= n_eff) begin
          r1 = r_ext + 1'b1;
          c1 = r1;
          adv_done = (r1 >= n_eff);
        end
      end
      FMT_LOWER_DG_ROW: begin
        c1 = c_ext + 1'b1;
        if (c1 > r_ext) begin
          r1 = r_ext + 1'b1;
          c1 = '0;
          adv_done = (r1 >= n_eff);
        end
      end
      FMT_UPPER_COL: begin
        r1 = r_ext + 1'b1;
        if (r1 >= c_ext) begin
          c1 = c_ext + 1'b1;
          r1 = '0;
          adv_done = (c1 >= n_eff);
        end
      end
      FMT_LOWER_COL: begin
        r1 = r_ext + 1'b1;
        if (r1 >= n_eff) begin
          c1 = c_ext + 1'b1;
          r1 = c_ext + CNT_W'(2);
          adv_done = (r1 >= n_eff);
        end
      end
      FMT_UPPER_DG_COL: begin
        r1 = r_ext + 1'b1;
        if (r1 > c_ext) begin
          c1 = c_ext + 1'b1;
          r1 = '0;
          adv_done = (c1 >= n_eff);
        end
      end
      FMT_LOWER_DG_COL: begin
        r1 = r_ext + 1'b1;
        if (r1 >= n_eff) begin
          c1 = c_ext + 1'b1;
          r1 = c1;
          adv_done = (c1 >= n_eff);
        end
      end
      default: begin
        c1 = c_ext + 1'b1;
        if (c1 >= n_eff) begin
          c1 = '0;
          r1 = r_ext + 1'b1;
          adv_done = (r1 >= n_eff);
        end
      end
    endcase
  end

  // configuration and section start
  always_comb begin
    fmt_nxt = fmt_r;
    nc_nxt  = nc_r;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_FORMAT: fmt_nxt = cfg_wdata[FMT_W-1:0];
        REG_NODES:  nc_nxt  = cfg_wdata[NC_W-1:0];
        default:    fmt_nxt = fmt_r;
      endcase
    end
    st_fmt  = eff_format(fmt_nxt);
    st_n    = eff_nodes(nc_nxt);
    st_row  = ((st_fmt == FMT_LOWER_ROW) || (st_fmt == FMT_LOWER_COL)) ? IDX_W'(1) : '0;
    st_col  = ((st_fmt == FMT_UPPER_ROW) || (st_fmt == FMT_UPPER_COL)) ? IDX_W'(1) : '0;
    st_full = (st_n == CNT_W'(1)) &&
              ((st_fmt == FMT_UPPER_ROW) || (st_fmt == FMT_LOWER_ROW) ||
               (st_fmt == FMT_UPPER_COL) || (st_fmt == FMT_LOWER_COL));
  end

  // result for the word at the input
  always_comb begin
    res       = '0;
    full_now  = section_full_r;
    extra_now = extra_seen_r || section_full_r;
    if (!section_full_r) begin
      res.row    = OUT_IDX_W'(cur_row_r);
      res.col    = OUT_IDX_W'(cur_col_r);
      res.value  = in_weight_in;
      res.wvalid = 1'b1;
      res.mirror = (fmt_eff != FMT_FULL);
      full_now   = adv_done;
    end
    if (in_last_value) begin
      priority if (extra_now) begin
        res.status = ST_EXTRA;
      end else if (full_now) begin
        res.status = ST_COMPLETE;
      end else begin
        res.status = ST_SHORT;
      end
    end else begin
      res.status = ST_PROGRESS;
    end
  end

  always_comb begin
    cur_row_nxt      = cur_row_r;
    cur_col_nxt      = cur_col_r;
    section_full_nxt = section_full_r;
    extra_seen_nxt   = extra_seen_r;
    if (cfg_wr_en || (in_fire && in_last_value)) begin
      cur_row_nxt      = st_row;
      cur_col_nxt      = st_col;
      section_full_nxt = st_full;
      extra_seen_nxt   = 1'b0;
    end else if (in_fire) begin
      section_full_nxt = full_now;
      extra_seen_nxt   = extra_now;
      if (!section_full_r) begin
        cur_row_nxt = adv_done ? '0 : IDX_W'(r1);
        cur_col_nxt = adv_done ? '0 : IDX_W'(c1);
      end
    end
  end

  // output register with skid stage
  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_res_nxt    = out_res_r;
    skid_res_nxt   = skid_res_r;
    if (in_fire) begin
      if (!out_valid_r || out_take) begin
        out_res_nxt   = res;
        out_valid_nxt = 1'b1;
      end else begin
        skid_res_nxt   = res;
        skid_valid_nxt = 1'b1;
      end
    end else if (out_take) begin
      if (skid_valid_r) begin
        out_res_nxt    = skid_res_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r          <= FMT_FULL;
      nc_r           <= NC_W'(1);
      cur_row_r      <= '0;
      cur_col_r      <= '0;
      section_full_r <= 1'b0;
      extra_seen_r   <= 1'b0;
      out_valid_r    <= 1'b0;
      skid_valid_r   <= 1'b0;
    end else begin
      fmt_r          <= fmt_nxt;
      nc_r           <= nc_nxt;
      cur_row_r      <= cur_row_nxt;
      cur_col_r      <= cur_col_nxt;
      section_full_r <= section_full_nxt;
      extra_seen_r   <= extra_seen_nxt;
      out_valid_r    <= out_valid_nxt;
      skid_valid_r   <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r  <= out_res_nxt;
    skid_res_r <= skid_res_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_write_row    = out_res_r.row;
  assign out_write_col    = out_res_r.col;
  assign out_write_value  = out_res_r.value;
  assign out_write_valid  = out_res_r.wvalid;
  assign out_mirror_write = out_res_r.mirror;
  assign out_status       = out_res_r.status;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid register holds a word while the output register is empty");

  a_cell_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    !section_full_r |-> (r_ext < n_eff) && (c_ext < n_eff))
    else $error("cell counter outside the matrix");

  a_close_clears_extra: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_last_value) |=> !extra_seen_r)
    else $error("extra flag survives a section close");

  a_extra_zeroed: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_write_valid) |->
      (out_write_row == '0) && (out_write_col == '0) && (out_write_value == '0) &&
      !out_mirror_write)
    else $error("extra word result carries a non-zero cell or weight");

endmodule

`default_nettype wire
